FILE: rtl/base64_stream_encoder_top_macros.svh
// Assertion macros shared by the checker of the Base64 stream encoder.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: label");

`endif

FILE: rtl/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

    localparam logic [6:0] C_PAD_CHAR   = 7'h3D;
    localparam logic [6:0] C_CHAR_UPPER = 7'd65;
    localparam logic [6:0] C_CHAR_LOWER = 7'd97;
    localparam logic [6:0] C_CHAR_DIGIT = 7'd48;
    localparam logic [6:0] C_CHAR_PLUS  = 7'd43;
    localparam logic [6:0] C_CHAR_SLASH = 7'd47;

    // Number of source bytes held by a group: one, two or three.
    localparam logic [1:0] C_HAVE_ONE   = 2'd1;
    localparam logic [1:0] C_HAVE_TWO   = 2'd2;
    localparam logic [1:0] C_HAVE_THREE = 2'd3;

    // One group handed from the front to the back.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  have;
        logic        eom;
    } t_group;

    function automatic logic [6:0] f_sextet_char(input logic [5:0] v);
        logic [6:0] c;
        logic [6:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            c = C_CHAR_UPPER + w;
        end else if (v < 6'd52) begin
            c = C_CHAR_LOWER + w - 7'd26;
        end else if (v < 6'd62) begin
            c = C_CHAR_DIGIT + w - 7'd52;
        end else if (v == 6'd62) begin
            c = C_CHAR_PLUS;
        end else begin
            c = C_CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

FILE: rtl/base64_stream_encoder_top.sv
`timescale 1ns / 1ps
// Streaming Base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per item on i_data_byte, with i_end_of_message
// high on the last byte of a message. An item is taken when push is high
// and full is low. Output channel: one ASCII character per item; the oldest
// character sits on o_out_char while empty is low and leaves when pop is high.
// o_group_last marks the fourth character of each group, o_message_last the
// fourth character of the group that ends a message.
// Every three bytes, or a shorter tail at the end of a message, make a group
// of four characters. A byte that completes a group is written to the group
// queue, and its first character then enters the output register; the rest
// follow one per cycle while pop is high. Bytes are taken one per cycle while
// full is low; the one-character output register limits the sustained rate.
// Up to P_FIFO_DEPTH finished groups wait between the byte assembler and the
// character serializer; full rises when that queue fills because the
// receiver stalls, and the output character holds until it is popped.
// Reset clears the held bytes and empties the group queue and the output register.
module base64_stream_encoder_top
    import b64e_pkg::*;
#(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_out_char,
    output logic       o_group_last,
    output logic       o_message_last
);

    logic   accept;
    logic   grp_wr;
    t_group grp_in;
    t_group grp_out;
    logic   grp_rd;
    logic   grp_empty;

    assign accept = push && !full;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_grp_wr         (grp_wr),
        .o_grp            (grp_in)
    );

    b64e_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (grp_wr),
        .i_wr_data (grp_in),
        .o_full    (full),
        .i_rd      (grp_rd),
        .o_rd_data (grp_out),
        .o_empty   (grp_empty)
    );

    b64e_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grp          (grp_out),
        .i_grp_empty    (grp_empty),
        .o_grp_rd       (grp_rd),
        .o_out_char     (o_out_char),
        .o_group_last   (o_group_last),
        .o_message_last (o_message_last),
        .o_empty        (empty),
        .i_pop          (pop)
    );

endmodule

FILE: rtl/b64e_fifo.sv
`timescale 1ns / 1ps

module b64e_fifo
    import b64e_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_group i_wr_data,
    output logic   o_full,
    input  logic   i_rd,
    output t_group o_rd_data,
    output logic   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_group        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/b64e_front.sv
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_grp_wr,
    output t_group     o_grp
);

    logic [15:0] r_bytes;
    logic [1:0]  r_count;
    logic [15:0] n_bytes;
    logic [1:0]  n_count;
    logic        complete;

    // A count of three never arises; it behaves like two.
    always_comb begin
        n_bytes   = r_bytes;
        n_count   = r_count;
        o_grp.eom = i_end_of_message;
        complete  = i_end_of_message || r_count[1];
        case (r_count)
            2'd0: begin
                o_grp.word = {i_data_byte, 16'h0000};
                o_grp.have = C_HAVE_ONE;
            end
            2'd1: begin
                o_grp.word = {r_bytes[15:8], i_data_byte, 8'h00};
                o_grp.have = C_HAVE_TWO;
            end
            default: begin
                o_grp.word = {r_bytes, i_data_byte};
                o_grp.have = C_HAVE_THREE;
            end
        endcase
        if (i_accept) begin
            if (complete) begin
                n_bytes = '0;
                n_count = '0;
            end else if (r_count == 2'd0) begin
                n_bytes = {i_data_byte, 8'h00};
                n_count = 2'd1;
            end else begin
                n_bytes = {r_bytes[15:8], i_data_byte};
                n_count = 2'd2;
            end
        end
    end

    assign o_grp_wr = i_accept && complete;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
            r_count <= '0;
        end else begin
            r_bytes <= n_bytes;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/b64e_back.sv
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_grp,
    input  logic       i_grp_empty,
    output logic       o_grp_rd,
    output logic [6:0] o_out_char,
    output logic       o_group_last,
    output logic       o_message_last,
    output logic       o_empty,
    input  logic       i_pop
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_glast;
    logic       r_mlast;

    logic       advance;
    logic [6:0] n_char;

    // The output register reloads whenever a group is waiting and the register is free or being drained.
    assign advance  = !i_grp_empty && (!r_valid || i_pop);
    assign o_grp_rd = advance && (r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    n_char = f_sextet_char(i_grp.word[23:18]);
            2'd1:    n_char = f_sextet_char(i_grp.word[17:12]);
            2'd2:    n_char = (i_grp.have >= C_HAVE_TWO) ?
                              f_sextet_char(i_grp.word[11:6]) : C_PAD_CHAR;
            default: n_char = (i_grp.have == C_HAVE_THREE) ?
                              f_sextet_char(i_grp.word[5:0]) : C_PAD_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx   <= r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char  <= n_char;
            r_glast <= (r_idx == 2'd3);
            r_mlast <= (r_idx == 2'd3) && i_grp.eom;
        end
    end

    assign o_out_char     = r_char;
    assign o_group_last   = r_glast;
    assign o_message_last = r_mlast;
    assign o_empty        = !r_valid;

endmodule

FILE: rtl/b64e_checker.sv
`timescale 1ns / 1ps
`include "base64_stream_encoder_top_macros.svh"

module b64e_checker
    import b64e_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [6:0] o_out_char,
    input logic       o_group_last,
    input logic       o_message_last
);

    // A waiting character that is not popped stays in place.
    `B64E_ASSERT_NEXT(a_hold_out, !empty && !pop, !empty && $stable(o_out_char))

    // The end of a message always closes a group.
    `B64E_ASSERT_NOW(a_mlast_glast, !empty && o_message_last, o_group_last)

    // Padding runs to the end of its group.
    `B64E_ASSERT_NEXT(a_pad_run,
        !empty && pop && (o_out_char == C_PAD_CHAR) && !o_group_last,
        empty || (o_out_char == C_PAD_CHAR))

    // The first character of a group is never padding.
    `B64E_ASSERT_NEXT(a_first_not_pad, !empty && pop && o_group_last,
        empty || (o_out_char != C_PAD_CHAR))

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import b64e_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES = 480;

    typedef struct packed {
        logic [6:0] ch;
        logic       group_end;
        logic       msg_end;
    } b64_char_t;

    // Tracks the held bytes of the current group and the characters
    // that the encoder still owes.
    class base64_text_tracker;
        string       alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        logic [15:0] held_bytes;
        int          held_count;
        b64_char_t   chars_due[$];
        int          mismatches;
        int          chars_seen;

        function new();
            held_bytes = 16'h0000;
            held_count = 0;
            mismatches = 0;
            chars_seen = 0;
        endfunction

        function logic [6:0] sextet_to_char(input logic [5:0] v);
            logic [7:0] c;
            c = alphabet[int'(v)];
            return c[6:0];
        endfunction

        function void take_byte(input logic [7:0] b, input logic eom);
            logic [23:0] word;
            int          have;
            b64_char_t   c;
            have = held_count + 1;
            if (have < 3 && !eom) begin
                if (held_count == 0) begin
                    held_bytes = {b, 8'h00};
                end else begin
                    held_bytes[7:0] = b;
                end
                held_count = have;
                return;
            end
            case (held_count)
                0: begin
                    word = {b, 16'h0000};
                end
                1: begin
                    word = {held_bytes[15:8], b, 8'h00};
                end
                default: begin
                    word = {held_bytes, b};
                end
            endcase
            c = '{sextet_to_char(word[23:18]), 1'b0, 1'b0};
            chars_due.push_back(c);
            c = '{sextet_to_char(word[17:12]), 1'b0, 1'b0};
            chars_due.push_back(c);
            c.ch = (have >= 2) ? sextet_to_char(word[11:6]) : C_PAD_CHAR;
            chars_due.push_back(c);
            c.ch = (have >= 3) ? sextet_to_char(word[5:0]) : C_PAD_CHAR;
            c.group_end = 1'b1;
            c.msg_end = eom;
            chars_due.push_back(c);
            held_bytes = 16'h0000;
            held_count = 0;
        endfunction

        task report_mismatch(input string what);
            $display("ERROR: char %0d: %s", chars_seen, what);
            mismatches++;
        endtask

        task match_char(input logic [6:0] ch, input logic gl, input logic ml);
            b64_char_t want;
            if (chars_due.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h", ch));
            end else begin
                want = chars_due.pop_front();
                if (ch !== want.ch)
                    report_mismatch($sformatf("out_char %h, want %h", ch, want.ch));
                if (gl !== want.group_end)
                    report_mismatch($sformatf("group_last %b, want %b", gl, want.group_end));
                if (ml !== want.msg_end)
                    report_mismatch($sformatf("message_last %b, want %b", ml, want.msg_end));
            end
            chars_seen++;
        endtask

        function int outstanding();
            return chars_due.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       i_end_of_message;
    logic       empty;
    logic       pop;
    logic [6:0] o_out_char;
    logic       o_group_last;
    logic       o_message_last;

    base64_text_tracker tracker = new();
    int idle_pct = 15;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    base64_stream_encoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_out_char       (o_out_char),
        .o_group_last     (o_group_last),
        .o_message_last   (o_message_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Outputs are read before the edge updates them, so accepted items
    // line up with the values the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                tracker.take_byte(i_data_byte, i_end_of_message);
            if (pop && !empty)
                tracker.match_char(o_out_char, o_group_last, o_message_last);
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("base64_stream_encoder_top: mismatch");
        $finish;
    end

    // Receiver: random pops, with one long hold-off on request.
    initial begin
        int i;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++) begin
                    pop <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                pop <= ($urandom_range(99) >= idle_pct);
                @(negedge i_clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item
    // was taken, leaving push high.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            i_data_byte <= 8'($urandom);
            i_end_of_message <= 1'($urandom);
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        i_end_of_message <= eom;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
            @(negedge i_clk);
        end
    endtask

    initial begin
        // {end_of_message, byte}: short tails, full groups, all-ones,
        // the plus and slash characters, and multi-group messages.
        logic [8:0] directed[24] = '{
            9'h100, 9'h1FF,
            9'h000, 9'h100, 9'h0FF, 9'h1FF,
            9'h000, 9'h000, 9'h100, 9'h0FF, 9'h0FF, 9'h1FF,
            9'h0FB, 9'h0EF, 9'h1BE,
            9'h04D, 9'h061, 9'h06E, 9'h121,
            9'h001, 9'h023, 9'h045, 9'h067, 9'h189
        };
        int sent;
        int len;
        int k;
        int roll;

        i_rst_n = 1'b0;
        push = 1'b0;
        i_data_byte = 8'h00;
        i_end_of_message = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n])
            send_byte(directed[n][7:0], directed[n][8]);

        // The receiver stalls at the start of the random part so that the
        // group queue fills and full holds off the sender.
        hold_req = 1'b1;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            idle_pct = (sent >= 160 && sent < 320) ? 0 : 15;
            roll = $urandom_range(99);
            if (roll < 80)
                len = $urandom_range(8, 1);
            else if (roll < 95)
                len = $urandom_range(24, 9);
            else
                len = $urandom_range(60, 25);
            for (k = 0; k < len; k++)
                send_byte(8'($urandom_range(255)), k == len - 1);
            sent += len;
        end
        push <= 1'b0;
        idle_pct = 15;

        while (tracker.outstanding() > 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("base64_stream_encoder_top: match");
        else
            $display("base64_stream_encoder_top: mismatch");
        $finish;
    end

endmodule
